>>> sv/mcst_pkg.sv
// Shared types and constants for the multi-channel software timer.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package mcst_pkg;

  localparam int FUNC_W   = 2;
  localparam int HANDLE_W = 8;
  localparam int COUNT_W  = 32;
  localparam int KIND_W   = 2;
  localparam int CHAN_W   = 4;

  // At most this many expiries are reported for one tick.
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  // Command queue between the front and the back part.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STOP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  count;
    logic                periodic;
  } cmd_t;

  // Head of the command queue as seen by the back part.
  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } queue_head_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] owner;
    logic [COUNT_W-1:0]  remaining;
    logic [COUNT_W-1:0]  period;
    logic                reload;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic                success;
    logic [CHAN_W-1:0]   chan;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

>>> sv/mcst_if.sv
// Handshake interfaces for the command and result channels of the timer.
// Depends on mcst_pkg for the field widths.
`default_nettype none

interface mcst_in_if;
  logic                          valid;
  logic                          ready;
  logic [mcst_pkg::FUNC_W-1:0]   func;
  logic [mcst_pkg::HANDLE_W-1:0] owner_handle;
  logic [mcst_pkg::COUNT_W-1:0]  load_count;
  logic                          is_periodic;

  modport source (output valid, func, owner_handle, load_count, is_periodic, input ready);
  modport sink   (input valid, func, owner_handle, load_count, is_periodic, output ready);
endinterface

interface mcst_out_if;
  logic                          valid;
  logic                          ready;
  logic [mcst_pkg::KIND_W-1:0]   result_kind;
  logic                          success;
  logic [mcst_pkg::CHAN_W-1:0]   channel_index;
  logic [mcst_pkg::HANDLE_W-1:0] expired_handle;
  logic                          last_result;

  modport source (output valid, result_kind, success, channel_index, expired_handle,
                  last_result, input ready);
  modport sink   (input valid, result_kind, success, channel_index, expired_handle,
                  last_result, output ready);
endinterface

`default_nettype wire

>>> sv/mcst_front.sv
// Front part: accepts command items, drops unused function codes and
// queues the rest for the back part. Depends on mcst_pkg and mcst_in_if.
`default_nettype none

module mcst_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  mcst_in_if.sink                    in_ch,
  output mcst_pkg::queue_head_t      head,
  input  wire logic                  pop
);

  mcst_pkg::cmd_t              q_r [mcst_pkg::QUEUE_DEPTH];
  logic [mcst_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [mcst_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [mcst_pkg::QCNT_W-1:0] cnt_r;
  logic                        keep;
  logic                        push;
  logic                        do_pop;

  always_comb begin
    unique case (in_ch.func) inside
      mcst_pkg::FUNC_TICK, mcst_pkg::FUNC_START, mcst_pkg::FUNC_STOP: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign in_ch.ready = (cnt_r != mcst_pkg::QCNT_W'(mcst_pkg::QUEUE_DEPTH));
  // An item with an unused code is accepted and simply not queued.
  assign push        = in_ch.valid && in_ch.ready && keep;
  assign do_pop      = pop && (cnt_r != '0);

  assign head.vld = (cnt_r != '0);
  assign head.cmd = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{func:     in_ch.func,
                         handle:   in_ch.owner_handle,
                         count:    in_ch.load_count,
                         periodic: in_ch.is_periodic};
    end
  end

  // The queue depth is a power of two, so the pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> sv/mcst_back.sv
// Back part: runs one queued command over the channel table, one channel per
// cycle unless a stalled result output holds it, and delivers its results through an output register.
// Depends on mcst_pkg and mcst_out_if.
`default_nettype none

module mcst_back #(
  parameter int CHANNEL_COUNT = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mcst_pkg::queue_head_t head,
  output logic                       pop,
  mcst_out_if.source                 out_ch
);

  localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int CNT_W = $clog2(CHANNEL_COUNT + 1);
  localparam logic [CNT_W-1:0] LAST_ADDR = CNT_W'(CHANNEL_COUNT);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                              state_r;
  mcst_pkg::cmd_t                      cmd_r;
  mcst_pkg::entry_t                    mem [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0]            live_r;
  logic [CNT_W-1:0]                    addr_r;
  logic                                p_vld_r;
  logic [IDX_W-1:0]                    p_idx_r;
  mcst_pkg::entry_t                    p_ent_r;
  logic                                p_live_r;
  logic                                found_r;
  logic [mcst_pkg::CHAN_W-1:0]         chan_r;
  logic                                any_r;
  logic                                held_vld_r;
  logic [mcst_pkg::CHAN_W-1:0]         held_chan_r;
  logic [mcst_pkg::HANDLE_W-1:0]       held_handle_r;
  logic [mcst_pkg::RES_W-1:0]          n_r;
  logic                                out_vld_r;
  mcst_pkg::result_t                   out_res_r;

  mcst_pkg::entry_t                    ent;
  mcst_pkg::entry_t                    wr_data;
  mcst_pkg::result_t                   final_res;
  logic [mcst_pkg::COUNT_W-1:0]        rem_dec;
  logic                                is_tick;
  logic                                is_start;
  logic                                is_stop;
  logic                                has_handle;
  logic                                dec;
  logic                                expire;
  logic                                report;
  logic                                need_out;
  logic                                out_free;
  logic                                p_go;
  logic                                issue;
  logic                                scan_end;
  logic                                start_hit;
  logic                                stop_hit;
  logic                                wr_en;
  logic                                fin_load;

  assign is_tick    = (cmd_r.func == mcst_pkg::FUNC_TICK);
  assign is_start   = (cmd_r.func == mcst_pkg::FUNC_START);
  assign is_stop    = (cmd_r.func == mcst_pkg::FUNC_STOP);
  assign has_handle = (cmd_r.handle != '0);

  // A channel never written since reset reads as all zero.
  assign ent      = p_live_r ? p_ent_r : '0;
  assign rem_dec  = ent.remaining - 1'b1;
  assign dec      = (ent.remaining != '0);
  assign expire   = dec && (rem_dec == '0);
  assign report   = p_vld_r && is_tick && expire &&
                    (n_r < mcst_pkg::RES_W'(mcst_pkg::MAX_RESULTS));
  // The newest expiry is held back until the next one or the end of the
  // scan shows whether it is the last result of the tick.
  assign need_out = report && held_vld_r;
  assign out_free = !out_vld_r || out_ch.ready;
  assign p_go     = p_vld_r && (!need_out || out_free);

  assign issue    = (state_r == S_SCAN) && (addr_r != LAST_ADDR) && (!p_vld_r || p_go);
  assign scan_end = (state_r == S_SCAN) && (addr_r == LAST_ADDR) && (!p_vld_r || p_go);
  assign pop      = (state_r == S_IDLE) && head.vld;
  assign fin_load = (state_r == S_DONE) && out_free;

  assign start_hit = is_start && has_handle && !found_r && (ent.owner == '0);
  assign stop_hit  = is_stop && has_handle && (ent.owner == cmd_r.handle);

  always_comb begin
    wr_en   = 1'b0;
    wr_data = ent;
    if (p_go) begin
      if (is_tick && dec) begin
        wr_en             = 1'b1;
        wr_data.remaining = (expire && ent.reload) ? ent.period : rem_dec;
      end else if (start_hit) begin
        wr_en   = 1'b1;
        wr_data = '{owner:     cmd_r.handle,
                    remaining: cmd_r.count,
                    period:    cmd_r.count,
                    reload:    cmd_r.periodic};
      end
    end
  end

  always_comb begin
    final_res = '{kind: mcst_pkg::KIND_IDLE, success: 1'b0, chan: '0, handle: '0, last: 1'b1};
    if (is_start) begin
      final_res.kind    = mcst_pkg::KIND_START;
      final_res.success = found_r;
      final_res.chan    = chan_r;
    end else if (is_stop) begin
      final_res.kind    = mcst_pkg::KIND_STOP;
      final_res.success = any_r;
    end else if (held_vld_r) begin
      final_res.kind   = mcst_pkg::KIND_EXPIRY;
      final_res.chan   = held_chan_r;
      final_res.handle = held_handle_r;
    end
  end

  // Channel table: one write port driven by the processing stage, one
  // registered read port driven by the scan address.
  always_ff @(posedge clk) begin
    if (wr_en) mem[p_idx_r] <= wr_data;
    if (issue) p_ent_r <= mem[addr_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_idx_r  <= addr_r[IDX_W-1:0];
      p_live_r <= live_r[addr_r[IDX_W-1:0]];
    end
    if (pop) cmd_r <= head.cmd;
    if (report && p_go) begin
      held_chan_r   <= mcst_pkg::CHAN_W'(p_idx_r);
      held_handle_r <= ent.owner;
    end
    if (start_hit && p_go) chan_r <= mcst_pkg::CHAN_W'(p_idx_r);
    else if (pop) chan_r <= '0;
    if (p_go && need_out) begin
      out_res_r <= '{kind: mcst_pkg::KIND_EXPIRY, success: 1'b0, chan: held_chan_r,
                     handle: held_handle_r, last: 1'b0};
    end else if (fin_load) begin
      out_res_r <= final_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      live_r     <= '0;
      addr_r     <= '0;
      p_vld_r    <= 1'b0;
      found_r    <= 1'b0;
      any_r      <= 1'b0;
      held_vld_r <= 1'b0;
      n_r        <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (issue) addr_r <= addr_r + 1'b1;
      else if (pop) addr_r <= '0;

      if (issue) p_vld_r <= 1'b1;
      else if (p_go) p_vld_r <= 1'b0;

      if (start_hit && p_go) live_r[p_idx_r] <= 1'b1;
      else if (stop_hit && p_go) live_r[p_idx_r] <= 1'b0;

      if (pop) begin
        found_r    <= 1'b0;
        any_r      <= 1'b0;
        held_vld_r <= 1'b0;
        n_r        <= '0;
      end else begin
        if (start_hit && p_go) found_r <= 1'b1;
        if (stop_hit && p_go) any_r <= 1'b1;
        if (report && p_go) begin
          held_vld_r <= 1'b1;
          n_r        <= n_r + 1'b1;
        end
      end

      if ((p_go && need_out) || fin_load) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;

      unique case (state_r)
        S_IDLE: if (pop) state_r <= S_SCAN;
        S_SCAN: if (scan_end) state_r <= S_DONE;
        S_DONE: if (fin_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.result_kind    = out_res_r.kind;
  assign out_ch.success        = out_res_r.success;
  assign out_ch.channel_index  = out_res_r.chan;
  assign out_ch.expired_handle = out_res_r.handle;
  assign out_ch.last_result    = out_res_r.last;

endmodule

`default_nettype wire

>>> sv/multi_channel_software_timer.sv
// Top level of the multi-channel software timer: command front end, queue
// and channel-scan back end. Depends on mcst_pkg, mcst_if, mcst_front, mcst_back.
//
//   Channel | Direction | Payload
//   in_ch   | in        | func, owner_handle, load_count, is_periodic
//   out_ch  | out       | result_kind, success, channel_index, expired_handle, last_result
//
// In the back end each command is taken from the queue, the channels are read
// in turn through the table's single read port, the last channel is drained
// and then the final result is presented.
// A stalled result output holds the scan only when a second expiry is ready.
// Reset is synchronous; it frees every channel at once through valid bits.
// Up to two commands wait in the queue while one is being executed.
`default_nettype none

module multi_channel_software_timer #(
  parameter int CHANNEL_COUNT = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mcst_in_if.sink    in_ch,
  mcst_out_if.source out_ch
);

  mcst_pkg::queue_head_t head;
  logic                  pop;

  mcst_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  mcst_back #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for multi_channel_software_timer: start, stop and tick items
// with random idling on both sides, checked against a timer table modeled in the bench.
// Depends on mcst_pkg, mcst_if and the timer RTL.
`timescale 1ns / 100ps

module tb;

  localparam int CHANNELS = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 190;
  localparam int DRAIN_CYCLES = 3 * (CHANNELS + 3);
  localparam logic [mcst_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  mcst_in_if  in_ch();
  mcst_out_if out_ch();

  multi_channel_software_timer #(.CHANNEL_COUNT(CHANNELS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Timer table as the bench expects it to be.
  logic [mcst_pkg::HANDLE_W-1:0] owner_tab  [CHANNELS];
  logic [mcst_pkg::COUNT_W-1:0]  remain_tab [CHANNELS];
  logic [mcst_pkg::COUNT_W-1:0]  period_tab [CHANNELS];
  logic                          reload_tab [CHANNELS];

  mcst_pkg::cmd_t    pending_cmds[$];
  mcst_pkg::result_t due_results[$];
  mcst_pkg::cmd_t    cur_cmd;
  int      total_cmds = 1;
  int      accepted = 0;
  int      errors = 0;
  int      cycles = 0;

  function automatic int phase_now();
    int p;
    p = accepted * 3 / total_cmds;
    return (p > 2) ? 2 : p;
  endfunction

  function automatic int send_idle_pct();
    case (phase_now())
      0: return 30;
      1: return 51;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (phase_now())
      0: return 51;
      1: return 30;
      default: return 0;
    endcase
  endfunction

  // Applies one item to the table and queues the results it should cause.
  task automatic timer_table_step(input mcst_pkg::cmd_t c);
    mcst_pkg::result_t got[$];
    mcst_pkg::result_t r;
    bit found;
    int i;
    found = 1'b0;
    r = '0;
    case (c.func)
      mcst_pkg::FUNC_TICK: begin
        for (i = 0; i < CHANNELS; i++) begin
          if (remain_tab[i] != '0) begin
            remain_tab[i] = remain_tab[i] - 1'b1;
            if (remain_tab[i] == '0) begin
              if (reload_tab[i]) remain_tab[i] = period_tab[i];
              if (got.size() < mcst_pkg::MAX_RESULTS) begin
                r = '0;
                r.kind = mcst_pkg::KIND_EXPIRY;
                r.chan = mcst_pkg::CHAN_W'(i);
                r.handle = owner_tab[i];
                got.push_back(r);
              end
            end
          end
        end
        if (got.size() == 0) begin
          r = '0;
          r.kind = mcst_pkg::KIND_IDLE;
          got.push_back(r);
        end
      end
      mcst_pkg::FUNC_START: begin
        r.kind = mcst_pkg::KIND_START;
        if (c.handle != '0) begin
          for (i = 0; i < CHANNELS && !found; i++) begin
            if (owner_tab[i] == '0) begin
              found = 1'b1;
              r.success = 1'b1;
              r.chan = mcst_pkg::CHAN_W'(i);
              owner_tab[i] = c.handle;
              remain_tab[i] = c.count;
              period_tab[i] = c.count;
              reload_tab[i] = c.periodic;
            end
          end
        end
        got.push_back(r);
      end
      mcst_pkg::FUNC_STOP: begin
        r.kind = mcst_pkg::KIND_STOP;
        if (c.handle != '0) begin
          for (i = 0; i < CHANNELS; i++) begin
            if (owner_tab[i] == c.handle) begin
              r.success = 1'b1;
              owner_tab[i] = '0;
              remain_tab[i] = '0;
              period_tab[i] = '0;
              reload_tab[i] = 1'b0;
            end
          end
        end
        got.push_back(r);
      end
      default: ;
    endcase
    if (got.size() != 0) begin
      got[got.size()-1].last = 1'b1;
      foreach (got[k]) due_results.push_back(got[k]);
    end
  endtask

  task automatic queue_cmd(input logic [mcst_pkg::FUNC_W-1:0] f,
                           input logic [mcst_pkg::HANDLE_W-1:0] h,
                           input logic [mcst_pkg::COUNT_W-1:0] n, input logic per);
    mcst_pkg::cmd_t c;
    c.func = f;
    c.handle = h;
    c.count = n;
    c.periodic = per;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [mcst_pkg::HANDLE_W-1:0] pick_handle();
    int r;
    r = $urandom_range(99);
    if (r < 80) return mcst_pkg::HANDLE_W'($urandom_range(1, 5));
    if (r < 88) return '0;
    return mcst_pkg::HANDLE_W'($urandom_range(255));
  endfunction

  function automatic logic [mcst_pkg::COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 78) return mcst_pkg::COUNT_W'($urandom_range(1, 6));
    if (r < 88) return '0;
    return mcst_pkg::COUNT_W'($urandom);
  endfunction

  function automatic logic [mcst_pkg::FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(99);
    if (r < 45) return mcst_pkg::FUNC_TICK;
    if (r < 78) return mcst_pkg::FUNC_START;
    if (r < 95) return mcst_pkg::FUNC_STOP;
    return FUNC_UNUSED;
  endfunction

  initial begin
    int made;
    int kind;
    int j;
    int reps;
    logic [mcst_pkg::COUNT_W-1:0] shared_count;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = mcst_pkg::FUNC_TICK;
    in_ch.owner_handle = '0;
    in_ch.load_count = '0;
    in_ch.is_periodic = 1'b0;
    out_ch.ready = 1'b0;
    for (j = 0; j < CHANNELS; j++) begin
      owner_tab[j] = '0;
      remain_tab[j] = '0;
      period_tab[j] = '0;
      reload_tab[j] = 1'b0;
    end

    // Directed part: empty-table tick, refused handle zero, extreme fields,
    // periodic and one-shot expiry, zero count, multi-channel stop, unused code.
    queue_cmd(mcst_pkg::FUNC_TICK, 8'd0, 32'd0, 1'b0);
    queue_cmd(mcst_pkg::FUNC_START, 8'd0, 32'd3, 1'b1);
    queue_cmd(mcst_pkg::FUNC_STOP, 8'd0, 32'd0, 1'b0);
    queue_cmd(mcst_pkg::FUNC_START, 8'd255, 32'hFFFF_FFFF, 1'b0);
    queue_cmd(mcst_pkg::FUNC_START, 8'd1, 32'd1, 1'b1);
    queue_cmd(mcst_pkg::FUNC_START, 8'd1, 32'd2, 1'b0);
    queue_cmd(mcst_pkg::FUNC_START, 8'd2, 32'd0, 1'b1);
    queue_cmd(mcst_pkg::FUNC_TICK, 8'd0, 32'd0, 1'b0);
    queue_cmd(mcst_pkg::FUNC_TICK, 8'hAA, 32'h5555_5555, 1'b1);
    queue_cmd(mcst_pkg::FUNC_TICK, 8'd0, 32'd0, 1'b0);
    queue_cmd(mcst_pkg::FUNC_STOP, 8'd1, 32'd0, 1'b0);
    queue_cmd(mcst_pkg::FUNC_STOP, 8'd1, 32'd0, 1'b0);
    queue_cmd(FUNC_UNUSED, 8'd7, 32'd1, 1'b1);
    queue_cmd(mcst_pkg::FUNC_TICK, 8'd0, 32'd0, 1'b0);
    queue_cmd(mcst_pkg::FUNC_STOP, 8'd255, 32'hFFFF_FFFF, 1'b1);
    queue_cmd(mcst_pkg::FUNC_STOP, 8'd2, 32'd0, 1'b0);

    // Random part, mostly in well-formed episodes. The first one fills the
    // table with a shared count so that every channel expires on one tick.
    made = 0;
    kind = 0;
    while (made < RANDOM_ITEMS) begin
      if (kind == 0) begin
        shared_count = mcst_pkg::COUNT_W'($urandom_range(1, 3));
        for (j = 0; j < CHANNELS + 2; j++)
          queue_cmd(mcst_pkg::FUNC_START, mcst_pkg::HANDLE_W'($urandom_range(1, 5)),
                    shared_count, 1'($urandom));
        reps = $urandom_range(3, 7);
        for (j = 0; j < reps; j++)
          queue_cmd(mcst_pkg::FUNC_TICK, mcst_pkg::HANDLE_W'($urandom),
                    mcst_pkg::COUNT_W'($urandom), 1'($urandom));
        for (j = 1; j <= 5; j++)
          queue_cmd(mcst_pkg::FUNC_STOP, mcst_pkg::HANDLE_W'(j),
                    mcst_pkg::COUNT_W'($urandom), 1'($urandom));
        made += CHANNELS + 7 + reps;
      end else if (kind < 65) begin
        reps = $urandom_range(1, 5);
        for (j = 0; j < reps; j++)
          queue_cmd(mcst_pkg::FUNC_START, pick_handle(), pick_count(), 1'($urandom));
        made += reps;
        reps = $urandom_range(1, 7);
        for (j = 0; j < reps; j++)
          queue_cmd(mcst_pkg::FUNC_TICK, mcst_pkg::HANDLE_W'($urandom),
                    mcst_pkg::COUNT_W'($urandom), 1'($urandom));
        made += reps;
        if ($urandom_range(1)) begin
          queue_cmd(mcst_pkg::FUNC_STOP, pick_handle(), mcst_pkg::COUNT_W'($urandom),
                    1'($urandom));
          made++;
        end
      end else begin
        queue_cmd(pick_func(), pick_handle(), pick_count(), 1'($urandom));
        made++;
      end
      kind = (kind == 0 && made < 40) ? $urandom_range(1, 99) : $urandom_range(99);
    end
    total_cmds = pending_cmds.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_ch.valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("multi_channel_software_timer: match");
    end else begin
      $display("multi_channel_software_timer: mismatch");
    end
    $finish;
  end

  // Command driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        timer_table_step(cur_cmd);
        accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          cur_cmd = pending_cmds.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func <= cur_cmd.func;
          in_ch.owner_handle <= cur_cmd.handle;
          in_ch.load_count <= cur_cmd.count;
          in_ch.is_periodic <= cur_cmd.periodic;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result monitor.
  always @(posedge clk) begin
    mcst_pkg::result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d channel %0d handle %0d",
                   $time, out_ch.result_kind, out_ch.channel_index, out_ch.expired_handle);
          errors++;
        end else begin
          want = due_results.pop_front();
          report_field("result_kind", 32'(want.kind), 32'(out_ch.result_kind));
          report_field("success", 32'(want.success), 32'(out_ch.success));
          report_field("channel_index", 32'(want.chan), 32'(out_ch.channel_index));
          report_field("expired_handle", 32'(want.handle), 32'(out_ch.expired_handle));
          report_field("last_result", 32'(want.last), 32'(out_ch.last_result));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("multi_channel_software_timer: mismatch");
      $finish;
    end
  end

endmodule

>>> files.f
sv/mcst_pkg.sv
sv/mcst_if.sv
sv/mcst_front.sv
sv/mcst_back.sv
sv/multi_channel_software_timer.sv
bench/tb.sv
